/* src/point_set_insert_closest_pair_assert.svh */
// ----------------------------------------------------------------------------
// point_set_insert_closest_pair_assert.svh
// Assertion macros for the closest pair point set.
// ----------------------------------------------------------------------------
`ifndef POINT_SET_INSERT_CLOSEST_PAIR_ASSERT_SVH
`define POINT_SET_INSERT_CLOSEST_PAIR_ASSERT_SVH

`ifndef SYNTHESIS
`define PSICP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PSICP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PSICP_ASSERT(lbl, prop, msg)
`define PSICP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/psicp_pkg.sv */
// ----------------------------------------------------------------------------
// psicp_pkg
// Transaction types and status codes of the closest pair point set.
// ----------------------------------------------------------------------------
`default_nettype none

package psicp_pkg;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_PAIR      = 3'd3;
  localparam logic [2:0] ST_FEW       = 3'd4;

  typedef struct packed {
    logic               command;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
  } in_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic        [32:0] min_distance;
    logic        [6:0]  point_total;
  } out_t;

endpackage

`default_nettype wire

/* src/psicp_cell.sv */
// ----------------------------------------------------------------------------
// psicp_cell
// One stored point. Updates the passing token (match flag or row best pair)
// and hands it to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psicp_cell
  import psicp_pkg::*;
#(
  parameter int CW   = 16,
  parameter int CNTW = 7,
  parameter int K    = 0,
  parameter int TW   = 3 + 4 * CW + 2 * (2 * CW + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [TW-1:0]   tok_i,
  output logic [TW-1:0]   tok_o,
  input  logic [CNTW-1:0] cnt_i,
  input  logic            wr_i,
  input  logic [CW-1:0]   wx_i,
  input  logic [CW-1:0]   wy_i,
  output logic [CW-1:0]   px_o,
  output logic [CW-1:0]   py_o
);

  localparam int DW = 2 * CW + 1;
  localparam logic [CNTW-1:0] KIDX = CNTW'(K);

  typedef struct packed {
    logic                 vld;
    logic                 qry;
    logic                 match;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [DW-1:0]        best_d;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic [DW-1:0]        tail_d;
  } tok_t;

  logic [CW-1:0]   x_q, y_q;
  tok_t            t_in, t_d, t_q;
  logic            hold, eq;
  logic signed [CW:0] dx, dy;
  logic [CW-1:0]   mx, my;
  logic [2*CW-1:0] sqx, sqy;
  logic [DW-1:0]   pair_d;

  assign t_in = tok_t'(tok_i);
  assign hold = KIDX < cnt_i;
  assign eq   = (x_q == t_in.px) && (y_q == t_in.py);
  assign dx   = {x_q[CW-1], x_q} - {t_in.px[CW-1], t_in.px};
  assign dy   = {y_q[CW-1], y_q} - {t_in.py[CW-1], t_in.py};
  assign mx   = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign my   = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign sqx  = mx * mx;
  assign sqy  = my * my;
  assign pair_d = DW'(sqx) + DW'(sqy);

  always_comb begin
    t_d = t_in;
    if (t_in.qry) begin
      t_d.tail_d = pair_d;
      if (hold && !eq && (pair_d < t_in.best_d)) begin
        t_d.best_d = pair_d;
        t_d.bx     = x_q;
        t_d.by     = y_q;
      end
    end else if (hold && eq) begin
      t_d.match = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && (cnt_i == KIDX)) begin
      x_q <= wx_i;
      y_q <= wy_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
    end else begin
      t_q <= t_d;
    end
  end

  assign tok_o = TW'(t_q);
  assign px_o  = x_q;
  assign py_o  = y_q;

endmodule

`default_nettype wire

/* src/point_set_insert_closest_pair.sv */
// ----------------------------------------------------------------------------
// point_set_insert_closest_pair
// Insert: one token walks the cell chain for a match.
// Query with n >= 2 points: one row token per point
// is issued each cycle and each walks the whole chain.
// Query with fewer than two points: no token is issued. One transaction at a time.
// Reset empties the set; stored coordinates are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_set_insert_closest_pair_assert.svh"

module point_set_insert_closest_pair
  import psicp_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = 2 * CW + 1;
  localparam int IW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int TW   = 3 + 4 * CW + 2 * DW;

  typedef struct packed {
    logic                 vld;
    logic                 qry;
    logic                 match;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [DW-1:0]        best_d;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic [DW-1:0]        tail_d;
  } tok_t;

  typedef enum logic [1:0] {IDLE, RUN, FIN} state_e;

  state_e              state_q;
  logic [CNTW-1:0]     cnt_q, pend_q, inj_left_q;
  logic [IW-1:0]       inj_idx_q;
  tok_t                tok_in_q, tok_exit;
  logic                qry_q, dup_q, first_q, out_valid_q;
  logic [DW-1:0]       g_d_q, init_d_q;
  logic signed [CW-1:0] g_ax_q, g_ay_q, g_bx_q, g_by_q, init_ax_q, init_ay_q;
  logic [CW-1:0]       ins_x_q, ins_y_q;
  out_t                out_q, res_d;
  logic                wr, can_load, use_init;
  logic [63:0]         dist_wide;

  logic [TW-1:0] chain [CAPACITY+1];
  logic [CW-1:0] cell_x [CAPACITY];
  logic [CW-1:0] cell_y [CAPACITY];

  assign chain[CAPACITY] = TW'(tok_in_q);
  assign tok_exit        = tok_t'(chain[0]);

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    psicp_cell #(.CW(CW), .CNTW(CNTW), .K(k), .TW(TW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[k+1]),
      .tok_o (chain[k]),
      .cnt_i (cnt_q),
      .wr_i  (wr),
      .wx_i  (ins_x_q),
      .wy_i  (ins_y_q),
      .px_o  (cell_x[k]),
      .py_o  (cell_y[k])
    );
  end

  assign can_load = !out_valid_q || !out_stall_i;
  assign wr = (state_q == FIN) && can_load && !qry_q && !dup_q &&
              (cnt_q != CNTW'(CAPACITY));
  assign use_init  = (init_d_q == g_d_q);
  assign dist_wide = 64'(g_d_q);

  always_comb begin
    res_d = '0;
    res_d.point_total = 7'(cnt_q);
    if (!qry_q) begin
      if (dup_q) begin
        res_d.status = ST_DUPLICATE;
      end else if (cnt_q == CNTW'(CAPACITY)) begin
        res_d.status = ST_FULL;
      end else begin
        res_d.status      = ST_INSERTED;
        res_d.point_total = 7'(cnt_q + 1'b1);
      end
    end else if (cnt_q < CNTW'(2)) begin
      res_d.status = ST_FEW;
    end else begin
      res_d.status       = ST_PAIR;
      res_d.min_distance = dist_wide[32:0];
      if (use_init) begin
        res_d.first_x  = 16'(init_ax_q);
        res_d.first_y  = 16'(init_ay_q);
        res_d.second_x = 16'($signed(cell_x[0]));
        res_d.second_y = 16'($signed(cell_y[0]));
      end else begin
        res_d.first_x  = 16'(g_ax_q);
        res_d.first_y  = 16'(g_ay_q);
        res_d.second_x = 16'(g_bx_q);
        res_d.second_y = 16'(g_by_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      pend_q      <= '0;
      inj_left_q  <= '0;
      inj_idx_q   <= '0;
      tok_in_q    <= '0;
      qry_q       <= 1'b0;
      dup_q       <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      g_d_q       <= '0;
      init_d_q    <= '0;
      g_ax_q      <= '0;
      g_ay_q      <= '0;
      g_bx_q      <= '0;
      g_by_q      <= '0;
      init_ax_q   <= '0;
      init_ay_q   <= '0;
      ins_x_q     <= '0;
      ins_y_q     <= '0;
    end else begin
      if ((state_q == FIN) && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            qry_q   <= in_data_i.command;
            first_q <= 1'b1;
            dup_q   <= 1'b0;
            if (!in_data_i.command) begin
              ins_x_q    <= CW'($unsigned(in_data_i.new_x));
              ins_y_q    <= CW'($unsigned(in_data_i.new_y));
              tok_in_q   <= '{vld: 1'b1,
                              px: CW'($unsigned(in_data_i.new_x)),
                              py: CW'($unsigned(in_data_i.new_y)),
                              default: '0};
              pend_q     <= CNTW'(1);
              inj_left_q <= '0;
              state_q    <= RUN;
            end else if (cnt_q < CNTW'(2)) begin
              state_q <= FIN;
            end else begin
              pend_q     <= cnt_q;
              inj_left_q <= cnt_q;
              inj_idx_q  <= IW'(cnt_q - 1'b1);
              state_q    <= RUN;
            end
          end
        end
        RUN: begin
          if (inj_left_q != '0) begin
            tok_in_q   <= '{vld: 1'b1, qry: 1'b1,
                            px: cell_x[inj_idx_q], py: cell_y[inj_idx_q],
                            best_d: '1, default: '0};
            inj_left_q <= inj_left_q - 1'b1;
            inj_idx_q  <= inj_idx_q - 1'b1;
          end else begin
            tok_in_q.vld <= 1'b0;
          end
          if (tok_exit.vld) begin
            pend_q <= pend_q - 1'b1;
            if (pend_q == CNTW'(1)) begin
              state_q <= FIN;
            end
            if (!qry_q) begin
              dup_q <= tok_exit.match;
            end else begin
              first_q <= 1'b0;
              if (first_q) begin
                init_d_q  <= tok_exit.tail_d;
                init_ax_q <= tok_exit.px;
                init_ay_q <= tok_exit.py;
              end
              if (first_q || (tok_exit.best_d < g_d_q)) begin
                g_d_q  <= tok_exit.best_d;
                g_ax_q <= tok_exit.px;
                g_ay_q <= tok_exit.py;
                g_bx_q <= tok_exit.bx;
                g_by_q <= tok_exit.by;
              end
            end
          end
        end
        FIN: begin
          if (can_load) begin
            out_q <= res_d;
            if (wr) begin
              cnt_q <= cnt_q + 1'b1;
            end
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PSICP_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNTW'(CAPACITY), "point count above capacity")
  `PSICP_ASSERT(a_exit_in_run, tok_exit.vld |-> state_q == RUN, "token left chain outside run")
  `PSICP_ASSERT(a_cnt_step, cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + 1'b1, "bad count step")

endmodule

`default_nettype wire

/* tb/point_set_checker.sv */
// ----------------------------------------------------------------------------
// point_set_checker
// Watches both channels of the closest pair point set, predicts each result
// from its own copy of the held points and compares field by field.
// ----------------------------------------------------------------------------
module point_set_checker
  import psicp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity = 64;

  logic signed [15:0] held_x [Capacity];
  logic signed [15:0] held_y [Capacity];
  int unsigned        held_n;
  out_t               expected_results [$];

  function automatic logic [32:0] squared_gap(int a, int b);
    longint dx, dy;
    dx = longint'(held_x[a]) - longint'(held_x[b]);
    dy = longint'(held_y[a]) - longint'(held_y[b]);
    return 33'(dx * dx + dy * dy);
  endfunction

  function automatic void enqueue_expected(out_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic out_t apply_command(in_t cmd);
    out_t r;
    bit   dup;
    int   ba, bb;
    logic [32:0] best, d;
    r = '0;
    if (cmd.command == 1'b0) begin
      dup = 1'b0;
      for (int k = 0; k < held_n; k++) begin
        if (held_x[k] == cmd.new_x && held_y[k] == cmd.new_y) dup = 1'b1;
      end
      if (dup) begin
        r.status = ST_DUPLICATE;
      end else if (held_n >= Capacity) begin
        r.status = ST_FULL;
      end else begin
        held_x[held_n] = cmd.new_x;
        held_y[held_n] = cmd.new_y;
        held_n++;
        r.status = ST_INSERTED;
      end
    end else if (held_n < 2) begin
      r.status = ST_FEW;
    end else begin
      ba = held_n - 1;
      bb = 0;
      best = squared_gap(ba, bb);
      for (int i = held_n - 1; i >= 0; i--) begin
        for (int j = held_n - 1; j >= 0; j--) begin
          if (i != j) begin
            d = squared_gap(i, j);
            if (d < best) begin
              best = d;
              ba = i;
              bb = j;
            end
          end
        end
      end
      r.status = ST_PAIR;
      r.first_x = held_x[ba];
      r.first_y = held_y[ba];
      r.second_x = held_x[bb];
      r.second_y = held_y[bb];
      r.min_distance = best;
    end
    r.point_total = 7'(held_n);
    return r;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e, a;
    if (!rst_ni) begin
      held_n = 0;
      fail_count_o <= 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        a = out_data_i;
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_results.pop_front();
          if (e !== a) begin
            fail_count_o <= fail_count_o + 1;
            if (e.status !== a.status)
              $error("status exp %0d got %0d", e.status, a.status);
            if (e.first_x !== a.first_x)
              $error("first_x exp %0d got %0d", e.first_x, a.first_x);
            if (e.first_y !== a.first_y)
              $error("first_y exp %0d got %0d", e.first_y, a.first_y);
            if (e.second_x !== a.second_x)
              $error("second_x exp %0d got %0d", e.second_x, a.second_x);
            if (e.second_y !== a.second_y)
              $error("second_y exp %0d got %0d", e.second_y, a.second_y);
            if (e.min_distance !== a.min_distance)
              $error("min_distance exp %0d got %0d", e.min_distance, a.min_distance);
            if (e.point_total !== a.point_total)
              $error("point_total exp %0d got %0d", e.point_total, a.point_total);
          end
        end
      end
      if (in_valid_i && !in_stall_i) enqueue_expected(apply_command(in_data_i));
    end
  end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives insert and query transactions into the closest pair point set with
// random idling and stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb
  import psicp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  int unsigned fail_count, pending;
  int unsigned send_idle = 0, recv_idle = 0, cycles = 0;
  bit          hold_off = 1'b0;
  logic signed [15:0] pool_x [8];
  logic signed [15:0] pool_y [8];

  point_set_insert_closest_pair dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  point_set_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send(in_t item);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y);
    in_t it;
    it = '0;
    it.new_x = x;
    it.new_y = y;
    send(it);
  endtask

  task automatic send_query();
    in_t it;
    it = '0;
    it.command = 1'b1;
    it.new_x = 16'($urandom);
    it.new_y = 16'($urandom);
    send(it);
  endtask

  task automatic random_item(bit dense);
    int k;
    k = $urandom_range(99);
    if (k < 20) begin
      send_query();
    end else if (dense) begin
      k = $urandom_range(7);
      send_point(pool_x[k] + 16'($urandom_range(3)), pool_y[k] - 16'($urandom_range(3)));
    end else begin
      send_point(16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_query();
    send_point(16'sh7fff, 16'sh7fff);
    send_query();
    send_point(16'sh7fff, 16'sh7fff);
    send_point(-16'sh8000, -16'sh8000);
    send_query();
    send_point(16'sh0000, 16'sh0000);
    send_point(-16'sh8000, 16'sh7fff);
    send_point(16'sh0001, 16'sh0000);
    send_point(16'sh0000, 16'sh0001);
    send_query();
    for (int i = 0; i < 8; i++) begin
      pool_x[i] = 16'($urandom);
      pool_y[i] = 16'($urandom);
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 68 : 0;
      recv_idle = (ph == 0) ? 68 : (ph == 1) ? 30 : 0;
      for (int n = 0; n < 340; n++) begin
        if (ph == 1 && n == 10) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (400) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        if (n % 120 == 0 && n != 0) begin
          // fill to capacity, then hit full and duplicate
          for (int f = 0; f < 70; f++) send_point(16'($urandom), 16'($urandom));
          send_point(16'sh7fff, 16'sh7fff);
          send_query();
        end
        random_item(n % 240 < 120);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
